// ----- hdl/rgbwa_pkg.sv -----
// Shared types and constants of the RGB to RGBW/RGBWA splitter.
package rgbwa_pkg;

    localparam int CH_W    = 16;
    localparam int NUM_CH  = 3;
    localparam int NUM_OUT = 5;

    typedef enum logic [2:0] {
        REG_WHITE_RED   = 3'd0,
        REG_WHITE_GREEN = 3'd1,
        REG_WHITE_BLUE  = 3'd2,
        REG_AMBER_RED   = 3'd3,
        REG_AMBER_GREEN = 3'd4,
        REG_AMBER_BLUE  = 3'd5,
        REG_AMBER_EN    = 3'd6,
        REG_OUTPUT_MAX  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] white_out;
        logic [CH_W-1:0] amber_out;
    } t_pix_out;

    typedef struct packed {
        t_reg_idx        index;
        logic [CH_W-1:0] value;
    } t_cfg_wr;

    // Pipeline advance and the valid bit entering a pipeline section.
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    localparam logic [CH_W-1:0] RST_WHITE_RED   = 16'd16384;
    localparam logic [CH_W-1:0] RST_WHITE_GREEN = 16'd16384;
    localparam logic [CH_W-1:0] RST_WHITE_BLUE  = 16'd16384;
    localparam logic [CH_W-1:0] RST_AMBER_RED   = 16'd16384;
    localparam logic [CH_W-1:0] RST_AMBER_GREEN = 16'd12288;
    localparam logic [CH_W-1:0] RST_AMBER_BLUE  = 16'd0;
    localparam logic            RST_AMBER_EN    = 1'b0;
    localparam logic [CH_W-1:0] RST_OUTPUT_MAX  = 16'd255;

endpackage

// ----- hdl/rgbwa_if.sv -----
// Valid/ready channel carrying one payload beat.
interface rgbwa_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/rgbwa_div.sv -----
// Three-lane pipelined restoring divider, one quotient bit per stage.
module rgbwa_div #(
    parameter int NB = 15,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rgbwa_pkg::t_pipe_ctl       i_ctl,
    input  logic [2:0][DW-1:0]         i_den,
    input  logic [2:0][DW-1:0]         i_rem,
    input  logic [2:0][NB-1:0]         i_num,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [2:0][NB-1:0]         o_quo,
    output logic [SW-1:0]              o_side
);

    logic [NB:0]               r_vld;
    logic [2:0][DW-1:0]        r_rem  [NB+1];
    logic [2:0][NB-1:0]        r_num  [NB+1];
    logic [2:0][NB-1:0]        r_quo  [NB+1];
    logic [SW-1:0]             r_side [NB+1];

    logic [2:0][DW-1:0]        n_rem  [NB];
    logic [2:0][NB-1:0]        n_num  [NB];
    logic [2:0][NB-1:0]        n_quo  [NB];

    // The partial remainder always stays below the divisor, so it fits DW bits.
    always_comb begin
        logic [DW:0] v_trial;
        logic        v_take;
        for (int s = 0; s < NB; s++) begin
            for (int l = 0; l < 3; l++) begin
                v_trial = {r_rem[s][l], r_num[s][l][NB-1]};
                v_take  = v_trial >= {1'b0, i_den[l]};
                n_rem[s][l] = v_take ? DW'(v_trial - {1'b0, i_den[l]}) : v_trial[DW-1:0];
                n_num[s][l] = r_num[s][l] << 1;
                n_quo[s][l] = {r_quo[s][l][NB-2:0], v_take};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[NB-1:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem[0]  <= i_rem;
            r_num[0]  <= i_num;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
            for (int s = 0; s < NB; s++) begin
                r_rem[s+1]  <= n_rem[s];
                r_num[s+1]  <= n_num[s];
                r_quo[s+1]  <= n_quo[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NB];
    assign o_quo  = r_quo[NB];
    assign o_side = r_side[NB];

endmodule

// ----- hdl/rgbwa_sub.sv -----
// Fraction selection and subtraction of fraction times LED color, three stages.
module rgbwa_sub #(
    parameter int F  = 15,
    parameter int CW = 16,
    parameter int SW = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rgbwa_pkg::t_pipe_ctl     i_ctl,
    input  logic [2:0][F-1:0]        i_quo,
    input  logic [2:0]               i_ge,
    input  logic [2:0][CW-1:0]       i_ch,
    input  logic [2:0][15:0]         i_col,
    input  logic                     i_act,
    input  logic [SW-1:0]            i_side,
    output logic                     o_vld,
    output logic [2:0][CW-1:0]       o_ch,
    output logic [F:0]               o_frac,
    output logic [SW-1:0]            o_side
);

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [2:0]            has;
    logic [2:0][F:0]       ratio;
    logic [F:0]            sel_gb;
    logic [F:0]            sel_all;

    logic [2:0]            r_vld;
    logic [F:0]            r1_f;
    logic [2:0][CW-1:0]    r1_ch;
    logic [SW-1:0]         r1_side;
    logic [2:0][F+16:0]    r2_prod;
    logic [F:0]            r2_f;
    logic [2:0][CW-1:0]    r2_ch;
    logic [SW-1:0]         r2_side;
    logic [2:0][CW-1:0]    r3_ch;
    logic [F:0]            r3_f;
    logic [SW-1:0]         r3_side;

    // A ratio of 1.0 or more is held at 1.0; the selection keeps its result
    // under that clamp, so the final cap at 1.0 is already in place.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            has[l]   = i_col[l] != '0;
            ratio[l] = !has[l] ? '0 : (i_ge[l] ? ONE : {1'b0, i_quo[l]});
        end
        sel_gb  = (ratio[1] > ratio[2] && has[2]) ? ratio[2] : ratio[1];
        sel_all = (ratio[0] > sel_gb && (has[2] || has[1])) ? sel_gb : ratio[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[1:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_f    <= i_act ? sel_all : '0;
            r1_ch   <= i_ch;
            r1_side <= i_side;
            for (int l = 0; l < 3; l++) begin
                r2_prod[l] <= (F+17)'(r1_f * i_col[l]);
            end
            r2_f    <= r1_f;
            r2_ch   <= r1_ch;
            r2_side <= r1_side;
            for (int l = 0; l < 3; l++) begin
                r3_ch[l] <= (r2_ch[l] > CW'(r2_prod[l][F+15:F]))
                          ? CW'(r2_ch[l] - CW'(r2_prod[l][F+15:F])) : '0;
            end
            r3_f    <= r2_f;
            r3_side <= r2_side;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_ch   = r3_ch;
    assign o_frac = r3_f;
    assign o_side = r3_side;

endmodule

// ----- hdl/rgbwa_scale.sv -----
// Scales five values in 0..1.0 to 0..output_max with round half up, two stages.
module rgbwa_scale #(
    parameter int F = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rgbwa_pkg::t_pipe_ctl     i_ctl,
    input  logic [4:0][F:0]          i_x,
    input  logic [15:0]              i_omax,
    output logic                     o_vld,
    output logic [4:0][15:0]         o_val
);

    localparam logic [F+16:0] HALF = (F+17)'(1) << (F-1);

    logic [1:0]            r_vld;
    logic [4:0]            r1_full;
    logic [4:0][F+15:0]    r1_prod;
    logic [4:0][15:0]      r2_val;
    logic [F+16:0]         sum [5];

    always_comb begin
        for (int l = 0; l < 5; l++) begin
            sum[l] = {1'b0, r1_prod[l]} + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[0], i_ctl.vld};
        end
    end

    // Inputs never exceed 1.0, so the top bit alone marks full scale.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int l = 0; l < 5; l++) begin
                r1_full[l] <= i_x[l][F];
                r1_prod[l] <= (F+16)'(i_x[l][F-1:0] * i_omax);
                r2_val[l]  <= r1_full[l] ? i_omax : sum[l][F+15:F];
            end
        end
    end

    assign o_vld = r_vld[1];
    assign o_val = r2_val;

endmodule

// ----- hdl/rgb_to_rgbwa_split.sv -----
// Top level: splits an RGB color onto red, green, blue, white and amber drives.
//
//  channel | dir | beat contents
//  i_pix   | in  | red_in, green_in, blue_in (unsigned fixed point, FRAC_BITS fraction)
//  i_cfg   | in  | index (register 0..7), value (16 bit)
//  o_pix   | out | red_out, green_out, blue_out, white_out, amber_out
//
// One color is taken every cycle while the skid is empty; the path runs through the
// four bit-per-stage dividers (two ratio, two rescale) plus subtract and scale stages.
// Reset is synchronous: it clears the valid bits and loads register reset values.
// i_pix stalls only when the output register and its one-beat skid are both full.
// i_cfg is always ready; user writes registers only while block is idle, unenforced.
module rgb_to_rgbwa_split #(
    parameter int FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbwa_if.sink       i_pix,
    rgbwa_if.sink       i_cfg,
    rgbwa_if.source     o_pix
);

    localparam int F   = FRAC_BITS;
    localparam int RW  = ((F > 17) ? F : 17) + 1;
    localparam int NBR = 16 + F;
    localparam int EW  = ((F + 1 > 16) ? F + 1 : 16) + 1;
    localparam logic [EW-1:0] ONE_E = EW'(1) << F;
    localparam logic [F:0]    ONE   = {1'b1, {F{1'b0}}};

    typedef struct packed {
        logic [2:0][15:0] ch;
        logic [2:0]       ge;
    } t_side_a;

    typedef struct packed {
        logic [2:0][15:0] ch;
        logic [F:0]       fw;
    } t_side_b;

    typedef struct packed {
        logic [2:0][RW-1:0] ch;
        logic [2:0]         ge;
        logic [F:0]         fw;
    } t_side_c;

    typedef struct packed {
        logic [2:0][F:0] clip;
        logic [2:0]      ge;
        logic [F:0]      fw;
        logic [F:0]      fa;
    } t_side_d;

    function automatic logic [15:0] min3(input logic [2:0][15:0] c);
        logic [15:0] m;
        m = c[0];
        if (c[1] < m) m = c[1];
        if (c[2] < m) m = c[2];
        return m;
    endfunction

    // Configuration registers.
    logic [2:0][15:0] r_wcol;
    logic [2:0][15:0] r_acol;
    logic             r_amb_en;
    logic [15:0]      r_omax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcol   <= {rgbwa_pkg::RST_WHITE_BLUE, rgbwa_pkg::RST_WHITE_GREEN,
                         rgbwa_pkg::RST_WHITE_RED};
            r_acol   <= {rgbwa_pkg::RST_AMBER_BLUE, rgbwa_pkg::RST_AMBER_GREEN,
                         rgbwa_pkg::RST_AMBER_RED};
            r_amb_en <= rgbwa_pkg::RST_AMBER_EN;
            r_omax   <= rgbwa_pkg::RST_OUTPUT_MAX;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                rgbwa_pkg::REG_WHITE_RED:   r_wcol[0] <= i_cfg.data.value;
                rgbwa_pkg::REG_WHITE_GREEN: r_wcol[1] <= i_cfg.data.value;
                rgbwa_pkg::REG_WHITE_BLUE:  r_wcol[2] <= i_cfg.data.value;
                rgbwa_pkg::REG_AMBER_RED:   r_acol[0] <= i_cfg.data.value;
                rgbwa_pkg::REG_AMBER_GREEN: r_acol[1] <= i_cfg.data.value;
                rgbwa_pkg::REG_AMBER_BLUE:  r_acol[2] <= i_cfg.data.value;
                rgbwa_pkg::REG_AMBER_EN:    r_amb_en  <= i_cfg.data.value[0];
                rgbwa_pkg::REG_OUTPUT_MAX:  r_omax    <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Rescale divisors: u is 1.0 minus the smallest color component, used only
    // when that component is below 1.0.
    logic [15:0] wmin;
    logic [15:0] amin;
    logic        w_upos;
    logic        a_upos;
    logic [F:0]  u_w;
    logic [F:0]  u_a;

    always_comb begin
        wmin   = min3(r_wcol);
        amin   = min3(r_acol);
        w_upos = EW'(wmin) < ONE_E;
        a_upos = r_amb_en && (EW'(amin) < ONE_E);
        u_w    = (F+1)'(ONE_E - EW'(wmin));
        u_a    = (F+1)'(ONE_E - EW'(amin));
    end

    // Pipeline advance: everything moves unless the skid holds a beat.
    logic                 r_out_vld;
    logic                 r_skid_vld;
    rgbwa_pkg::t_pix_out  r_out;
    rgbwa_pkg::t_pix_out  r_skid;
    logic                 pipe_en;

    assign pipe_en     = !r_skid_vld;
    assign i_pix.ready = pipe_en;

    // White ratio divider.
    logic [2:0][15:0]     in_ch;
    t_side_a              side_a_in;
    logic [2:0][15:0]     rem_w;
    rgbwa_pkg::t_pipe_ctl ctl_in;
    logic                 dwr_vld;
    logic [2:0][F-1:0]    dwr_quo;
    t_side_a              dwr_side;

    always_comb begin
        in_ch[0] = i_pix.data.red_in;
        in_ch[1] = i_pix.data.green_in;
        in_ch[2] = i_pix.data.blue_in;
        side_a_in.ch = in_ch;
        for (int l = 0; l < 3; l++) begin
            side_a_in.ge[l] = in_ch[l] >= r_wcol[l];
            rem_w[l]        = side_a_in.ge[l] ? '0 : in_ch[l];
        end
        ctl_in.en  = pipe_en;
        ctl_in.vld = i_pix.valid;
    end

    rgbwa_div #(.NB(F), .DW(16), .SW($bits(t_side_a))) u_div_wr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_in),
        .i_den  (r_wcol),
        .i_rem  (rem_w),
        .i_num  ('0),
        .i_side (side_a_in),
        .o_vld  (dwr_vld),
        .o_quo  (dwr_quo),
        .o_side (dwr_side)
    );

    // White subtraction.
    rgbwa_pkg::t_pipe_ctl ctl_sw;
    logic                 sw_vld;
    logic [2:0][15:0]     sw_ch;
    logic [F:0]           sw_f;

    assign ctl_sw.en  = pipe_en;
    assign ctl_sw.vld = dwr_vld;

    rgbwa_sub #(.F(F), .CW(16), .SW(1)) u_sub_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_sw),
        .i_quo  (dwr_quo),
        .i_ge   (dwr_side.ge),
        .i_ch   (dwr_side.ch),
        .i_col  (r_wcol),
        .i_act  (1'b1),
        .i_side (1'b0),
        .o_vld  (sw_vld),
        .o_ch   (sw_ch),
        .o_frac (sw_f),
        .o_side ()
    );

    // White rescale divider: residual * 2^F / u.
    rgbwa_pkg::t_pipe_ctl ctl_ws;
    t_side_b              side_b_in;
    logic [2:0][NBR-1:0]  num_ws;
    logic                 dws_vld;
    logic [2:0][NBR-1:0]  dws_quo;
    t_side_b              dws_side;

    always_comb begin
        ctl_ws.en    = pipe_en;
        ctl_ws.vld   = sw_vld;
        side_b_in.ch = sw_ch;
        side_b_in.fw = sw_f;
        for (int l = 0; l < 3; l++) begin
            num_ws[l] = {sw_ch[l], {F{1'b0}}};
        end
    end

    rgbwa_div #(.NB(NBR), .DW(F+1), .SW($bits(t_side_b))) u_div_ws (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_ws),
        .i_den  ({u_w, u_w, u_w}),
        .i_rem  ('0),
        .i_num  (num_ws),
        .i_side (side_b_in),
        .o_vld  (dws_vld),
        .o_quo  (dws_quo),
        .o_side (dws_side)
    );

    // Amber ratio divider. A residual held at the all-ones value of RW bits
    // behaves downstream exactly like any larger one.
    rgbwa_pkg::t_pipe_ctl ctl_ar;
    t_side_c              side_c_in;
    logic [2:0][15:0]     rem_a;
    logic                 dar_vld;
    logic [2:0][F-1:0]    dar_quo;
    t_side_c              dar_side;

    always_comb begin
        ctl_ar.en    = pipe_en;
        ctl_ar.vld   = dws_vld;
        side_c_in.fw = dws_side.fw;
        for (int l = 0; l < 3; l++) begin
            if (!w_upos) begin
                side_c_in.ch[l] = RW'(dws_side.ch[l]);
            end else if (|dws_quo[l][NBR-1:RW]) begin
                side_c_in.ch[l] = '1;
            end else begin
                side_c_in.ch[l] = dws_quo[l][RW-1:0];
            end
            side_c_in.ge[l] = side_c_in.ch[l] >= RW'(r_acol[l]);
            rem_a[l]        = side_c_in.ge[l] ? '0 : side_c_in.ch[l][15:0];
        end
    end

    rgbwa_div #(.NB(F), .DW(16), .SW($bits(t_side_c))) u_div_ar (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_ar),
        .i_den  (r_acol),
        .i_rem  (rem_a),
        .i_num  ('0),
        .i_side (side_c_in),
        .o_vld  (dar_vld),
        .o_quo  (dar_quo),
        .o_side (dar_side)
    );

    // Amber subtraction; with amber off the fraction is zero and nothing changes.
    rgbwa_pkg::t_pipe_ctl ctl_sa;
    logic                 sa_vld;
    logic [2:0][RW-1:0]   sa_ch;
    logic [F:0]           sa_f;
    logic [F:0]           sa_fw;

    assign ctl_sa.en  = pipe_en;
    assign ctl_sa.vld = dar_vld;

    rgbwa_sub #(.F(F), .CW(RW), .SW(F+1)) u_sub_a (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_sa),
        .i_quo  (dar_quo),
        .i_ge   (dar_side.ge),
        .i_ch   (dar_side.ch),
        .i_col  (r_acol),
        .i_act  (r_amb_en),
        .i_side (dar_side.fw),
        .o_vld  (sa_vld),
        .o_ch   (sa_ch),
        .o_frac (sa_f),
        .o_side (sa_fw)
    );

    // Final rescale: only the part below 1.0 matters for the outputs.
    rgbwa_pkg::t_pipe_ctl ctl_ur;
    t_side_d              side_d_in;
    logic [2:0][F:0]      rem_u;
    logic                 dur_vld;
    logic [2:0][F-1:0]    dur_quo;
    t_side_d              dur_side;

    always_comb begin
        ctl_ur.en    = pipe_en;
        ctl_ur.vld   = sa_vld;
        side_d_in.fw = sa_fw;
        side_d_in.fa = sa_f;
        for (int l = 0; l < 3; l++) begin
            side_d_in.clip[l] = (sa_ch[l] >= RW'(ONE)) ? ONE : sa_ch[l][F:0];
            side_d_in.ge[l]   = sa_ch[l] >= RW'(u_a);
            rem_u[l]          = side_d_in.ge[l] ? '0 : sa_ch[l][F:0];
        end
    end

    rgbwa_div #(.NB(F), .DW(F+1), .SW($bits(t_side_d))) u_div_ur (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_ur),
        .i_den  ({u_a, u_a, u_a}),
        .i_rem  (rem_u),
        .i_num  ('0),
        .i_side (side_d_in),
        .o_vld  (dur_vld),
        .o_quo  (dur_quo),
        .o_side (dur_side)
    );

    // Output scaling.
    rgbwa_pkg::t_pipe_ctl ctl_sc;
    logic [4:0][F:0]      sc_x;
    logic                 sc_vld;
    logic [4:0][15:0]     sc_val;

    always_comb begin
        ctl_sc.en  = pipe_en;
        ctl_sc.vld = dur_vld;
        for (int l = 0; l < 3; l++) begin
            if (a_upos) begin
                sc_x[l] = dur_side.ge[l] ? ONE : {1'b0, dur_quo[l]};
            end else begin
                sc_x[l] = dur_side.clip[l];
            end
        end
        sc_x[3] = dur_side.fw;
        sc_x[4] = dur_side.fa;
    end

    rgbwa_scale #(.F(F)) u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl_sc),
        .i_x    (sc_x),
        .i_omax (r_omax),
        .o_vld  (sc_vld),
        .o_val  (sc_val)
    );

    // Output register with a one-beat skid behind it.
    rgbwa_pkg::t_pix_out pipe_out;

    always_comb begin
        pipe_out.red_out   = sc_val[0];
        pipe_out.green_out = sc_val[1];
        pipe_out.blue_out  = sc_val[2];
        pipe_out.white_out = sc_val[3];
        pipe_out.amber_out = sc_val[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_pix.ready) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (sc_vld) begin
            if (!r_out_vld || o_pix.ready) begin
                r_out     <= pipe_out;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= pipe_out;
                r_skid_vld <= 1'b1;
            end
        end else if (o_pix.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_pix.valid = r_out_vld;
    assign o_pix.data  = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a beat while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_pix.ready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid beat changed or vanished while stalled");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sc_vld && r_out_vld && !o_pix.ready && !r_skid_vld) |=> r_skid_vld)
        else $error("finished beat was not captured in the skid");

endmodule
